// File: src/heat_diffusion_burn_depth_top_assert.svh
// assertion helpers for the burn depth block
`ifndef HEAT_DIFFUSION_BURN_DEPTH_TOP_ASSERT_SVH
`define HEAT_DIFFUSION_BURN_DEPTH_TOP_ASSERT_SVH

// implication into the next cycle, quiet during reset
`define HDBD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// same-cycle implication, quiet during reset
`define HDBD_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// what reset leaves behind in the cycle after it is sampled
`define HDBD_ASSERT_RESET(name, cons, msg) \
  name: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

// File: src/hdbd_pkg.sv
`default_nettype none
package hdbd_pkg;

  localparam int RATE_DEPTH = 64;
  localparam int RATE_W     = $clog2(RATE_DEPTH);
  localparam int DMG_W      = 48;

  localparam logic [47:0] DAMAGE_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] FIRST_DEG_Q88 = 16'd11264;
  localparam logic [7:0]  BASE_DEGREE = 8'd44;

  // register indexes of the configuration port
  localparam logic [2:0] REG_CHEESE_CELLS = 3'd0;
  localparam logic [2:0] REG_TISSUE_CELLS = 3'd1;
  localparam logic [2:0] REG_MOUTH_TEMP   = 3'd2;
  localparam logic [2:0] REG_TOTAL_STEPS  = 3'd3;
  localparam logic [2:0] REG_COEFF_CHEESE = 3'd4;
  localparam logic [2:0] REG_COEFF_TISSUE = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_DIFF,
    ST_DAMG,
    ST_SCAN,
    ST_FINISH
  } hdbd_state_t;

  typedef logic [DMG_W-1:0] rate_tab_t [RATE_DEPTH];

  // v * ratio / 2^30, rounded half up, saturated to 48 bits
  function automatic logic [63:0] scale_entry(input logic [63:0] v, input logic [63:0] ratio);
    logic [63:0] hi;
    logic [63:0] p;
    logic [63:0] res;
    hi  = (v >> 24) * ratio;
    p   = ((hi & 64'd63) << 24) + (v & 64'hFF_FFFF) * ratio + (64'd1 << 29);
    res = (hi >> 6) + (p >> 30);
    return (res > {16'd0, DAMAGE_MAX}) ? {16'd0, DAMAGE_MAX} : res;
  endfunction

  // per-degree damage increments, built at elaboration
  function automatic rate_tab_t build_rate(input logic third);
    rate_tab_t   tab;
    logic [63:0] v;
    v = third ? 64'd1853 : 64'd3574;
    for (int k = 0; k < RATE_DEPTH; k++) begin
      if (third && k < 4) begin
        tab[k] = '0;
      end else begin
        tab[k] = v[DMG_W-1:0];
        v = scale_entry(v, third ? 64'd1917744130 : 64'd1848084377);
      end
    end
    return tab;
  endfunction

  localparam rate_tab_t RATE_SECOND = build_rate(1'b0);
  localparam rate_tab_t RATE_THIRD  = build_rate(1'b1);

endpackage
`default_nettype wire

// File: src/hdbd_ram.sv
`default_nettype none
module hdbd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: src/heat_diffusion_burn_depth_top.sv
// one request at a time: the next word can be taken in the cycle after the result is
//   registered; a result still held by the receiver stalls the end of the following run
// every step sweeps the temperature ram for diffusion (grids of three cells or more) and once more with the damage ram
// reset: synchronous, active high; registers take their reset values, no ram clearing
`default_nettype none
module heat_diffusion_burn_depth_top #(
  parameter int MAX_CELLS  = 512,
  parameter int MAX_TISSUE = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // start_temp[15:0], contact_steps[39:16]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [23:0] m_tdata,   // depth_first, depth_second, depth_third
  input  wire logic        cfg_wen,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [23:0] cfg_wdata
);
  import hdbd_pkg::*;

  localparam int CW = $clog2(MAX_CELLS);
  localparam int TW = $clog2(MAX_TISSUE);
  localparam int NW = $clog2(MAX_CELLS + 1);
  localparam int SW = ((NW > 9) ? NW : 9) + 1;
  localparam int EW = 2 * DMG_W + 1;   // flag, third, second

  // configuration registers
  logic [7:0]  cheese_cells;
  logic [8:0]  tissue_cells;
  logic [15:0] mouth_temp;
  logic [23:0] total_steps;
  logic [14:0] coeff_cheese;
  logic [14:0] coeff_tissue;

  always_ff @(posedge clk) begin
    if (rst) begin
      cheese_cells <= 8'd20;
      tissue_cells <= 9'd50;
      mouth_temp   <= 16'd9472;
      total_steps  <= 24'd1428;
      coeff_cheese <= 15'd6103;
      coeff_tissue <= 15'd6554;
    end else if (cfg_wen) begin
      case (cfg_addr)
        REG_CHEESE_CELLS: cheese_cells <= cfg_wdata[7:0];
        REG_TISSUE_CELLS: tissue_cells <= cfg_wdata[8:0];
        REG_MOUTH_TEMP:   mouth_temp   <= cfg_wdata[15:0];
        REG_TOTAL_STEPS:  total_steps  <= cfg_wdata;
        REG_COEFF_CHEESE: coeff_cheese <= cfg_wdata[14:0];
        REG_COEFF_TISSUE: coeff_tissue <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // grid clamping at request time
  logic [SW-1:0] nt_c, nc_c;
  always_comb begin
    nt_c = SW'(tissue_cells);
    if (nt_c == '0) nt_c = SW'(1);
    if (nt_c > SW'(MAX_TISSUE)) nt_c = SW'(MAX_TISSUE);
    if (nt_c > SW'(MAX_CELLS)) nt_c = SW'(MAX_CELLS);
    nc_c = SW'(cheese_cells);
    if (nc_c + nt_c > SW'(MAX_CELLS)) nc_c = SW'(MAX_CELLS) - nt_c;
  end

  // request state
  hdbd_state_t state, state_next;
  logic [15:0] start_temp;
  logic [23:0] contact;
  logic [NW-1:0] nc, nt, nx;
  logic [23:0] step;
  logic [NW-1:0] p, q;        // issue pointer and address of the word arriving
  logic          pv;          // read data valid this cycle
  logic [15:0] left, cur;     // old values of the two cells behind the read
  logic [7:0]  d1, d2, d3;

  // ram ports
  logic            t_we, d_we;
  logic [CW-1:0]   t_wa, t_ra;
  logic [15:0]     t_wd, t_rd;
  logic [TW-1:0]   d_wa, d_ra;
  logic [EW-1:0]   d_wd, d_rd;

  hdbd_ram #(.WIDTH(16), .DEPTH(MAX_CELLS)) u_temp_ram (
    .clk, .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd)
  );
  hdbd_ram #(.WIDTH(EW), .DEPTH(MAX_TISSUE)) u_damage_ram (
    .clk, .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd)
  );

  // sweep bookkeeping
  logic [NW-1:0] limit;
  logic issue, last, copy, deep, sweep_done;
  assign limit = (state == ST_DIFF) ? nx : nt;
  assign issue = ((state == ST_DIFF) || (state == ST_DAMG) || (state == ST_SCAN)) && (p < limit);
  assign last  = pv && (q == limit - NW'(1));
  assign copy  = (step > contact) && (nt >= NW'(2));
  assign deep  = (nx >= NW'(3));
  assign sweep_done = (step == total_steps - 24'd1);

  // diffusion of cell q-1 from old left, old centre and right arriving now
  logic signed [17:0] lap;
  logic signed [33:0] prod;
  logic signed [18:0] delta;
  logic signed [19:0] t_new;
  logic [14:0]        r;
  logic [15:0]        t_sat;
  logic [NW-1:0]      upd_idx;
  always_comb begin
    upd_idx = q - NW'(1);
    r     = (upd_idx < nc) ? coeff_cheese : coeff_tissue;
    lap   = $signed({2'b00, left}) + $signed({2'b00, t_rd}) - $signed({1'b0, cur, 1'b0});
    prod  = lap * $signed({1'b0, r});
    delta = 19'((prod + 34'sd32768) >>> 16);
    t_new = $signed({4'b0000, cur}) + 20'(delta);
    if (t_new < 0) t_sat = 16'd0;
    else if (t_new > 20'sd65535) t_sat = 16'hFFFF;
    else t_sat = t_new[15:0];
  end

  // damage update for tissue cell q; temperature comes from the ram read
  logic [7:0]        deg;
  logic [RATE_W-1:0] k;
  logic [DMG_W:0]    s2, s3;
  logic [EW-1:0]     d_upd;
  always_comb begin
    deg = t_rd[15:8];
    k   = ((deg - BASE_DEGREE) > 8'(RATE_DEPTH - 1)) ? RATE_W'(RATE_DEPTH - 1)
                                                      : RATE_W'(deg - BASE_DEGREE);
    s2 = {1'b0, d_rd[DMG_W-1:0]} + {1'b0, RATE_SECOND[k]};
    s3 = {1'b0, d_rd[2*DMG_W-1:DMG_W]} + {1'b0, RATE_THIRD[k]};
    d_upd = d_rd;
    if (t_rd >= FIRST_DEG_Q88) d_upd[EW-1] = 1'b1;
    if (deg >= BASE_DEGREE) begin
      d_upd[DMG_W-1:0]       = s2[DMG_W] ? DAMAGE_MAX : s2[DMG_W-1:0];
      d_upd[2*DMG_W-1:DMG_W] = s3[DMG_W] ? DAMAGE_MAX : s3[DMG_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_INIT;
      ST_INIT: begin
        if (p == nx - NW'(1)) begin
          if (total_steps == '0) state_next = ST_SCAN;
          else state_next = deep ? ST_DIFF : ST_DAMG;
        end
      end
      ST_DIFF: if (last) state_next = ST_DAMG;
      ST_DAMG: begin
        if (last) begin
          if (sweep_done) state_next = ST_SCAN;
          else state_next = deep ? ST_DIFF : ST_DAMG;
        end
      end
      ST_SCAN: if (last) state_next = ST_FINISH;
      ST_FINISH: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // ram control per state
  always_comb begin
    t_we = 1'b0;
    t_wa = '0;
    t_wd = '0;
    t_ra = '0;
    d_we = 1'b0;
    d_wa = '0;
    d_wd = '0;
    d_ra = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_INIT: begin
        t_we = 1'b1;
        t_wa = p[CW-1:0];
        t_wd = (p < nc) ? start_temp : mouth_temp;
        d_we = (p < nt);
        d_wa = p[TW-1:0];
      end
      ST_DIFF: begin
        t_ra = p[CW-1:0];
        t_we = pv && (q >= NW'(2));
        t_wa = upd_idx[CW-1:0];
        t_wd = t_sat;
      end
      ST_DAMG: begin
        // once contact is over the first tissue cell takes its deeper neighbour
        t_ra = ((p == '0) && copy) ? CW'(nc + NW'(1)) : CW'(nc + p);
        d_ra = p[TW-1:0];
        t_we = pv && (q == '0) && copy;
        t_wa = nc[CW-1:0];
        t_wd = t_rd;
        d_we = pv;
        d_wa = q[TW-1:0];
        d_wd = d_upd;
      end
      ST_SCAN: d_ra = p[TW-1:0];
      default: ;
    endcase
  end

  function automatic logic [7:0] sat8(input logic [NW-1:0] v);
    return (32'(v) > 32'd255) ? 8'hFF : v[7:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      p        <= '0;
      pv       <= 1'b0;
      m_tvalid <= 1'b0;
      left     <= '0;
    end else begin
      state <= state_next;
      q     <= p;
      // a finished sweep restarts the pointer, also when the state repeats
      if ((state_next != state) || last) begin
        p  <= '0;
        pv <= 1'b0;
      end else begin
        pv <= issue;
        if (issue || (state == ST_INIT)) p <= p + NW'(1);
      end
      if ((state == ST_FINISH) && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            start_temp <= s_tdata[15:0];
            contact    <= s_tdata[39:16];
            nc   <= NW'(nc_c);
            nt   <= NW'(nt_c);
            nx   <= NW'(nc_c + nt_c);
            step <= '0;
            d1 <= '0;
            d2 <= '0;
            d3 <= '0;
          end
        end
        ST_DIFF: begin
          if (pv) begin
            left <= cur;
            cur  <= t_rd;
          end
        end
        ST_DAMG: if (last) step <= step + 24'd1;
        ST_SCAN: begin
          if (pv) begin
            if (d_rd[EW-1]) d1 <= sat8(q);
            if (d_rd[DMG_W-1:32] != '0) d2 <= sat8(q);
            if (d_rd[2*DMG_W-1:DMG_W+32] != '0) d3 <= sat8(q);
          end
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {d3, d2, d1};
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: src/hdbd_checker.sv
`default_nettype none
`include "heat_diffusion_burn_depth_top_assert.svh"
module hdbd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata
);
  // after reset the block is empty and ready for a word
  `HDBD_ASSERT_RESET(a_reset_empty, !m_tvalid && s_tready, "reset left block busy")
  // one request at a time: a taken word closes the input
  `HDBD_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "second word taken")
  // a result only appears at the end of a simulation run
  `HDBD_ASSERT_NOW(a_result_after_run, $rose(m_tvalid), !$past(s_tready), "result without run")
  // a stalled result holds
  `HDBD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
    "result dropped")
endmodule

bind heat_diffusion_burn_depth_top hdbd_checker u_hdbd_checker (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
`default_nettype wire

// File: tb/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hdbd_pkg::*;

  // ---------------------------------------------------------------------------
  // burn depth predictor and store of expected depths
  // ---------------------------------------------------------------------------
  class burn_scoreboard;
    // register copies, reset values
    int unsigned cheese_cells = 20;
    int unsigned tissue_cells = 50;
    int unsigned mouth_temp   = 9472;
    int unsigned total_steps  = 1428;
    int unsigned coeff_cheese = 6103;
    int unsigned coeff_tissue = 6554;

    longint unsigned second_rate [64];
    longint unsigned third_rate  [64];
    int unsigned     cell_temp   [512];
    longint unsigned second_dmg  [256];
    longint unsigned third_dmg   [256];
    bit              blister     [256];

    logic [23:0] depth_q [$];
    int          mismatches = 0;

    function new();
      longint unsigned v2;
      longint unsigned v3;
      v2 = 3574;
      v3 = 1853;
      for (int k = 0; k < 64; k++) begin
        second_rate[k] = v2;
        v2 = grow(v2, 1848084377);
        if (k < 4) begin
          third_rate[k] = 0;
        end else begin
          third_rate[k] = v3;
          v3 = grow(v3, 1917744130);
        end
      end
    endfunction

    // multiply by a Q2.30 ratio, round half up, clip to 48 bits
    function longint unsigned grow(longint unsigned v, longint unsigned ratio);
      logic [95:0] acc;
      acc = (96'(v) * 96'(ratio) + (96'd1 << 29)) >> 30;
      return (acc > 96'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : 64'(acc);
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
        REG_CHEESE_CELLS: cheese_cells = val[7:0];
        REG_TISSUE_CELLS: tissue_cells = val[8:0];
        REG_MOUTH_TEMP:   mouth_temp   = val[15:0];
        REG_TOTAL_STEPS:  total_steps  = val[23:0];
        REG_COEFF_CHEESE: coeff_cheese = val[14:0];
        REG_COEFF_TISSUE: coeff_tissue = val[14:0];
        default: ;
      endcase
    endfunction

    function int unsigned diffuse(int unsigned l, int unsigned m, int unsigned r,
                                  int unsigned c);
      longint lap;
      longint t;
      lap = longint'(l) + longint'(r) - 2 * longint'(m);
      t   = longint'(m) + ((lap * longint'(c) + 32768) >>> 16);
      if (t < 0) t = 0;
      if (t > 65535) t = 65535;
      return int'(t);
    endfunction

    // run the whole simulation for one request and queue its depths
    function void note_request(logic [15:0] start_temp, logic [23:0] contact);
      int unsigned nt, nc, nx, cur, lft, t, k;
      int unsigned d1, d2, d3;
      longint unsigned s;
      nt = tissue_cells;
      if (nt < 1) nt = 1;
      if (nt > 256) nt = 256;
      nc = cheese_cells;
      if (nc + nt > 512) nc = 512 - nt;
      nx = nc + nt;
      d1 = 0; d2 = 0; d3 = 0;
      for (int i = 0; i < nx; i++) cell_temp[i] = (i < nc) ? start_temp : mouth_temp;
      for (int i = 0; i < nt; i++) begin
        second_dmg[i] = 0;
        third_dmg[i]  = 0;
        blister[i]    = 0;
      end
      for (int unsigned n = 0; n < total_steps; n++) begin
        if (nx >= 3) begin
          lft = cell_temp[0];
          for (int i = 1; i + 1 < nx; i++) begin
            cur = cell_temp[i];
            cell_temp[i] = diffuse(lft, cur, cell_temp[i+1],
                                   (i < nc) ? coeff_cheese : coeff_tissue);
            lft = cur;
          end
        end
        // contact released: surface cell follows the one beneath it
        if (n > contact && nt >= 2) cell_temp[nc] = cell_temp[nc+1];
        for (int i = 0; i < nt; i++) begin
          t = cell_temp[nc+i];
          if (t >= 44 * 256) blister[i] = 1;
          if ((t >> 8) >= 44) begin
            k = (t >> 8) - 44;
            if (k > 63) k = 63;
            s = second_dmg[i] + second_rate[k];
            second_dmg[i] = (s > 64'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : s;
            s = third_dmg[i] + third_rate[k];
            third_dmg[i] = (s > 64'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : s;
          end
        end
      end
      for (int i = 0; i < nt; i++) begin
        if (blister[i]) d1 = i;
        if (second_dmg[i] >= 64'h1_0000_0000) d2 = i;
        if (third_dmg[i] >= 64'h1_0000_0000) d3 = i;
      end
      if (d1 > 255) d1 = 255;
      if (d2 > 255) d2 = 255;
      if (d3 > 255) d3 = 255;
      depth_q.push_back({d3[7:0], d2[7:0], d1[7:0]});
    endfunction

    function void check_depths(logic [23:0] got);
      logic [23:0] want;
      if (depth_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
        return;
      end
      want = depth_q.pop_front();
      for (int f = 0; f < 3; f++) begin
        if (got[f*8 +: 8] !== want[f*8 +: 8]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("depth field %0d: expected %0d, got %0d", f, want[f*8 +: 8],
                     got[f*8 +: 8]);
        end
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // signals and block
  // ---------------------------------------------------------------------------
  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // start_temp[15:0], contact_steps[39:16]
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // depth_first[7:0], depth_second[15:8], depth_third[23:16]
  logic        cfg_wen;
  logic [2:0]  cfg_addr;
  logic [23:0] cfg_wdata;

  burn_scoreboard sb = new();

  bit quiet_sides = 0;   // no idling on either side while set
  int hold_off    = 0;   // receiver stall length requested by the sequence

  heat_diffusion_burn_depth_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // generous limit, well beyond the slowest legal run
  initial begin
    #30ms;
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random backpressure, plus a long hold-off on request
  initial begin
    int left;
    left = 0;
    m_tready = 0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        left = hold_off;
        hold_off = 0;
      end
      if (left > 0) begin
        left--;
        m_tready <= 0;
      end else begin
        m_tready <= quiet_sides ? 1'b1 : ($urandom_range(99) >= 19);
      end
    end
  end

  // result checking on every accepted word
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_depths(m_tdata);
  end

  // ---------------------------------------------------------------------------
  // driving tasks
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_wen   <= 1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic setup_grid(int unsigned cc, int unsigned tc, int unsigned mt,
                            int unsigned steps, int unsigned kc, int unsigned kt);
    write_reg(REG_CHEESE_CELLS, 24'(cc));
    write_reg(REG_TISSUE_CELLS, 24'(tc));
    write_reg(REG_MOUTH_TEMP, 24'(mt));
    write_reg(REG_TOTAL_STEPS, 24'(steps));
    write_reg(REG_COEFF_CHEESE, 24'(kc));
    write_reg(REG_COEFF_TISSUE, 24'(kt));
    cfg_wen <= 0;
    @(posedge clk);
  endtask

  task automatic send_request(logic [15:0] temp, logic [23:0] contact);
    int gap;
    if (!quiet_sides && $urandom_range(99) < 19) begin
      s_tvalid <= 0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {contact, temp};
    do @(posedge clk); while (!s_tready);
    sb.note_request(temp, contact);
  endtask

  task automatic drain;
    s_tvalid <= 0;
    while (sb.depth_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // random request, contact mostly within the run
  task automatic random_request;
    logic [23:0] contact;
    contact = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 45));
    send_request(16'($urandom_range(0, 65535)), contact);
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    cfg_wen = 0;
    cfg_addr = '0;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // small grid, hot and cold cheese, contact never and always released
    setup_grid(4, 6, 9472, 20, 6103, 6554);
    send_request(16'h0000, 24'h000000);
    send_request(16'hFFFF, 24'h000000);
    send_request(16'hFFFF, 24'hFFFFFF);
    send_request(16'hFFFF, 24'd5);
    send_request(16'h3C00, 24'd19);
    send_request(16'h4000, 24'd3);
    drain;

    // unused register indexes must be ignored
    write_reg(3'd6, 24'hFFFFFF);
    write_reg(3'd7, 24'h000000);
    cfg_wen <= 0;
    @(posedge clk);
    send_request(16'hC000, 24'd2);
    drain;

    // largest grid, maximum coefficients, few steps
    setup_grid(255, 256, 65535, 3, 32767, 32767);
    send_request(16'hFFFF, 24'd0);
    send_request(16'h0000, 24'd1);
    drain;

    // tissue count above the limit gets clamped
    setup_grid(255, 511, 12000, 2, 0, 32767);
    send_request(16'hFFFF, 24'd0);
    drain;

    // tiny grids: zero tissue read as one, and two cells with no interior
    setup_grid(0, 0, 65535, 500, 32767, 32767);
    send_request(16'hFFFF, 24'd0);
    drain;
    setup_grid(1, 1, 11264, 300, 100, 100);
    send_request(16'hFFFF, 24'd0);
    drain;

    // no steps at all, then zero diffusion with hot tissue
    setup_grid(3, 5, 65535, 0, 0, 0);
    send_request(16'hFFFF, 24'd0);
    drain;
    setup_grid(3, 5, 16'h3000, 40, 0, 0);
    send_request(16'hFFFF, 24'd0);
    send_request(16'h1234, 24'hABCDEF);
    drain;

    // random phases: small grids with random content
    for (int ph = 0; ph < 6; ph++) begin
      setup_grid($urandom_range(0, 12), $urandom_range(1, 12),
                 $urandom_range(8000, 65535), $urandom_range(1, 40),
                 $urandom_range(0, 32767), $urandom_range(0, 32767));
      quiet_sides = (ph == 2);
      for (int n = 0; n < 15; n++) begin
        // long receiver hold-off while requests keep coming
        if (ph == 1 && n == 3) hold_off = 20000;
        // sender waits for every outstanding result before going on
        if (ph == 3 && n == 7) drain;
        random_request();
      end
      drain;
    end
    quiet_sides = 0;

    s_tvalid <= 0;
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.depth_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
